// ----- rtl/core/can_acceptance_filter_table_assert.svh -----
// Assertion macros shared by the filter table RTL.
`ifndef CAN_ACCEPTANCE_FILTER_TABLE_ASSERT_SVH
`define CAN_ACCEPTANCE_FILTER_TABLE_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define CAFT_ASSERT_SAME(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed: %m");

// Next-cycle implication, checked outside reset.
`define CAFT_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed: %m");

`endif

// ----- rtl/core/caft_pkg.sv -----
// Shared types and constants for the CAN acceptance filter tables.
package caft_pkg;

	localparam int STD_ID_W      = 11;
	localparam int EXT_ID_W      = 29;
	localparam int MBOX_W        = 8;
	localparam int SLOT_OUT_W    = 4;
	localparam int EN_W          = 2;
	localparam int DEF_STD_SLOTS = 16;
	localparam int DEF_EXT_SLOTS = 8;

	localparam logic [EN_W-1:0] EN_DISABLED = 2'd0;

	typedef enum logic [1:0] {
		ST_OK          = 2'd0,
		ST_BAD_MAILBOX = 2'd1,
		ST_FULL        = 2'd2,
		ST_NOT_FOUND   = 2'd3
	} status_t;

	localparam logic OP_ADD    = 1'b0;
	localparam logic OP_REMOVE = 1'b1;

	typedef struct packed {
		logic [EN_W-1:0]     en;
		logic [STD_ID_W-1:0] ident;
		logic [STD_ID_W-1:0] mask;
	} std_entry_t;

	typedef struct packed {
		logic [EN_W-1:0]     en;
		logic [EXT_ID_W-1:0] ident;
		logic [EXT_ID_W-1:0] mask;
	} ext_entry_t;

	// controller -> datapath
	typedef struct packed {
		logic load;
		logic scan;
		logic commit;
	} caft_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic scan_done;
		logic out_free;
	} caft_stat_t;

endpackage

// ----- rtl/core/caft_ctrl.sv -----
// Sequencer for one filter request: load, table scan, commit.
module caft_ctrl
	import caft_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       item_valid,
	output logic       item_stall,
	input  caft_stat_t stat,
	output caft_cmd_t  cmd
);

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_COMMIT
	} state_t;

	state_t state_q;
	logic   stall_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			stall_q <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (item_valid) begin
						state_q <= S_SCAN;
						stall_q <= 1'b1;
					end
				end
				S_SCAN: begin
					if (stat.scan_done) begin
						state_q <= S_COMMIT;
					end
				end
				S_COMMIT: begin
					if (stat.out_free) begin
						state_q <= S_IDLE;
						stall_q <= 1'b0;
					end
				end
				default: begin
					state_q <= S_IDLE;
					stall_q <= 1'b0;
				end
			endcase
		end
	end

	assign item_stall = stall_q;

	always_comb begin
		cmd        = '0;
		cmd.load   = (state_q == S_IDLE) && item_valid;
		cmd.scan   = (state_q == S_SCAN);
		cmd.commit = (state_q == S_COMMIT) && stat.out_free;
	end

endmodule

// ----- rtl/core/caft_datapath.sv -----
// Request registers, filter table memories, scan compare and result register.
module caft_datapath
	import caft_pkg::*;
#(
	parameter int STD_SLOTS = DEF_STD_SLOTS,
	parameter int EXT_SLOTS = DEF_EXT_SLOTS
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  caft_cmd_t             cmd,
	output caft_stat_t            stat,
	input  logic                  op,
	input  logic                  is_extended,
	input  logic [EXT_ID_W-1:0]   frame_id,
	input  logic [EXT_ID_W-1:0]   id_mask,
	input  logic [MBOX_W-1:0]     fifo_sel,
	output logic                  result_valid,
	input  logic                  result_stall,
	output logic [1:0]            status,
	output logic [SLOT_OUT_W-1:0] slot_index,
	output logic                  was_update,
	output logic                  reject_std_unmatched,
	output logic                  reject_ext_unmatched
);

	localparam int MAX_SLOTS = (STD_SLOTS > EXT_SLOTS) ? STD_SLOTS : EXT_SLOTS;
	localparam int SCAN_W    = $clog2(MAX_SLOTS + 1);
	localparam int STD_AW    = (STD_SLOTS > 1) ? $clog2(STD_SLOTS) : 1;
	localparam int EXT_AW    = (EXT_SLOTS > 1) ? $clog2(EXT_SLOTS) : 1;
	localparam int IDX_W     = (STD_AW > EXT_AW) ? STD_AW : EXT_AW;
	localparam logic [SCAN_W-1:0] STD_N = SCAN_W'(STD_SLOTS);
	localparam logic [SCAN_W-1:0] EXT_N = SCAN_W'(EXT_SLOTS);

	// latched request
	logic                op_q;
	logic                ext_q;
	logic [EXT_ID_W-1:0] ident_q;
	logic [EXT_ID_W-1:0] mask_q;
	logic                mbox_ok_q;
	logic                mbox_q;

	// scan state
	logic [SCAN_W-1:0] rd_idx_q;
	logic              issue;
	logic [SCAN_W-1:0] n_slots;
	logic              cmp_vld_s1;
	logic [IDX_W-1:0]  cmp_idx_s1;
	logic              hit_found_q;
	logic [IDX_W-1:0]  hit_idx_q;
	logic [EXT_ID_W-1:0] hit_mask_q;
	logic              free_found_q;
	logic [IDX_W-1:0]  free_idx_q;

	// tables
	std_entry_t std_mem [STD_SLOTS];
	ext_entry_t ext_mem [EXT_SLOTS];
	logic [STD_SLOTS-1:0] std_vld_q;
	logic [EXT_SLOTS-1:0] ext_vld_q;
	std_entry_t std_rd_s1;
	ext_entry_t ext_rd_s1;
	logic       std_rv_s1;
	logic       ext_rv_s1;

	logic [EN_W-1:0]     ent_en;
	logic [EXT_ID_W-1:0] ent_id;
	logic [EXT_ID_W-1:0] ent_mask;

	// commit decision
	logic            wr_en;
	logic [IDX_W-1:0] wr_idx;
	logic [EN_W-1:0] wr_code;
	logic [EXT_ID_W-1:0] wr_mask;
	status_t         res_status;
	logic            res_upd;
	logic [IDX_W+SLOT_OUT_W-1:0] slot_wide;

	logic reject_std_q;
	logic reject_ext_q;
	logic result_valid_q;

	assign n_slots = ext_q ? EXT_N : STD_N;
	assign issue   = cmd.scan && (rd_idx_q != n_slots);

	// request latch, payload only
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q      <= op;
			ext_q     <= is_extended;
			ident_q   <= is_extended ? frame_id :
				{{(EXT_ID_W-STD_ID_W){1'b0}}, frame_id[STD_ID_W-1:0]};
			mask_q    <= is_extended ? id_mask :
				{{(EXT_ID_W-STD_ID_W){1'b0}}, id_mask[STD_ID_W-1:0]};
			mbox_ok_q <= (fifo_sel[MBOX_W-1:1] == '0);
			mbox_q    <= fifo_sel[0];
		end
	end

	// scan counter and first-hit / first-free tracking
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_idx_q     <= '0;
			cmp_vld_s1   <= 1'b0;
			hit_found_q  <= 1'b0;
			free_found_q <= 1'b0;
		end else if (cmd.load) begin
			rd_idx_q     <= '0;
			cmp_vld_s1   <= 1'b0;
			hit_found_q  <= 1'b0;
			free_found_q <= 1'b0;
		end else begin
			cmp_vld_s1 <= issue;
			if (issue) begin
				rd_idx_q <= rd_idx_q + 1'b1;
			end
			if (cmp_vld_s1) begin
				if (!hit_found_q && (ent_id == ident_q)) begin
					hit_found_q <= 1'b1;
				end
				if (!free_found_q && (ent_en == EN_DISABLED)) begin
					free_found_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			cmp_idx_s1 <= rd_idx_q[IDX_W-1:0];
		end
		if (cmp_vld_s1 && !hit_found_q && (ent_id == ident_q)) begin
			hit_idx_q  <= cmp_idx_s1;
			hit_mask_q <= ent_mask;
		end
		if (cmp_vld_s1 && !free_found_q && (ent_en == EN_DISABLED)) begin
			free_idx_q <= cmp_idx_s1;
		end
	end

	// an entry never written reads as all zero
	always_comb begin
		if (ext_q) begin
			ent_en   = ext_rv_s1 ? ext_rd_s1.en : EN_DISABLED;
			ent_id   = ext_rv_s1 ? ext_rd_s1.ident : '0;
			ent_mask = ext_rv_s1 ? ext_rd_s1.mask : '0;
		end else begin
			ent_en   = std_rv_s1 ? std_rd_s1.en : EN_DISABLED;
			ent_id   = std_rv_s1 ? {{(EXT_ID_W-STD_ID_W){1'b0}}, std_rd_s1.ident} : '0;
			ent_mask = std_rv_s1 ? {{(EXT_ID_W-STD_ID_W){1'b0}}, std_rd_s1.mask} : '0;
		end
	end

	// commit decision
	always_comb begin
		wr_en      = 1'b0;
		wr_idx     = hit_found_q ? hit_idx_q : free_idx_q;
		wr_code    = EN_DISABLED;
		res_status = ST_OK;
		res_upd    = 1'b0;
		if (op_q == OP_REMOVE) begin
			if (hit_found_q) begin
				wr_en = 1'b1;
			end else begin
				res_status = ST_NOT_FOUND;
			end
		end else if (!mbox_ok_q) begin
			res_status = ST_BAD_MAILBOX;
		end else if (hit_found_q || free_found_q) begin
			wr_en   = 1'b1;
			wr_code = {1'b0, mbox_q} + 2'd1;
			res_upd = hit_found_q;
		end else begin
			res_status = ST_FULL;
		end
	end

	// remove only clears the enable code; the stored mask is written back
	assign wr_mask = (op_q == OP_REMOVE) ? hit_mask_q : mask_q;

	assign slot_wide = (res_status == ST_OK) ?
		{{SLOT_OUT_W{1'b0}}, wr_idx} : '0;

	// table memories: one read port for the scan, one write port for commit
	always_ff @(posedge clk) begin
		if (issue && !ext_q) begin
			std_rd_s1 <= std_mem[rd_idx_q[STD_AW-1:0]];
		end
		if (issue && ext_q) begin
			ext_rd_s1 <= ext_mem[rd_idx_q[EXT_AW-1:0]];
		end
		if (cmd.commit && wr_en && !ext_q) begin
			std_mem[wr_idx[STD_AW-1:0]] <= '{en: wr_code,
				ident: ident_q[STD_ID_W-1:0], mask: wr_mask[STD_ID_W-1:0]};
		end
		if (cmd.commit && wr_en && ext_q) begin
			ext_mem[wr_idx[EXT_AW-1:0]] <= '{en: wr_code, ident: ident_q, mask: wr_mask};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			std_vld_q <= '0;
			ext_vld_q <= '0;
			std_rv_s1 <= 1'b0;
			ext_rv_s1 <= 1'b0;
		end else begin
			if (issue && !ext_q) begin
				std_rv_s1 <= std_vld_q[rd_idx_q[STD_AW-1:0]];
			end
			if (issue && ext_q) begin
				ext_rv_s1 <= ext_vld_q[rd_idx_q[EXT_AW-1:0]];
			end
			if (cmd.commit && wr_en && !ext_q) begin
				std_vld_q[wr_idx[STD_AW-1:0]] <= 1'b1;
			end
			if (cmd.commit && wr_en && ext_q) begin
				ext_vld_q[wr_idx[EXT_AW-1:0]] <= 1'b1;
			end
		end
	end

	// sticky flags and result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			reject_std_q   <= 1'b0;
			reject_ext_q   <= 1'b0;
			result_valid_q <= 1'b0;
		end else begin
			if (cmd.commit) begin
				result_valid_q <= 1'b1;
			end else if (!result_stall) begin
				result_valid_q <= 1'b0;
			end
			if (cmd.commit && wr_en && (op_q == OP_ADD)) begin
				if (ext_q) begin
					reject_ext_q <= 1'b1;
				end else begin
					reject_std_q <= 1'b1;
				end
			end
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			status     <= res_status;
			slot_index <= slot_wide[SLOT_OUT_W-1:0];
			was_update <= res_upd;
		end
	end

	assign result_valid         = result_valid_q;
	assign reject_std_unmatched = reject_std_q;
	assign reject_ext_unmatched = reject_ext_q;

	assign stat.scan_done = (rd_idx_q == n_slots) && !cmp_vld_s1;
	assign stat.out_free  = !result_valid_q || !result_stall;

endmodule

// ----- rtl/core/can_acceptance_filter_table.sv -----
// Top level of the CAN acceptance filter table block.
// Keeps two acceptance filter tables, STD_SLOTS entries for 11-bit identifiers
// and EXT_SLOTS entries for 29-bit identifiers, and serves one add or remove
// request per transfer. A request scans the selected table one entry per cycle
// through the table memory's single read port, noting the first entry whose
// stored identifier equals the request identifier (disabled entries included)
// and the first disabled entry, then commits at most one write and one result.
// item_stall stays high from the transfer until the result is loaded, so no new
// request is taken while one is scanning or waiting to commit. The result
// register decouples the output side: a new request is taken while the
// previous result still waits, and its commit is held until that result leaves.
// Add with a mailbox other than 0 or 1 reports invalid mailbox; add with no
// match and no free slot reports table full; remove with no match reports
// not found; none of these change state. A successful add writes enable code
// mailbox+1, the identifier and the mask, and sets that class's sticky
// reject-unmatched flag. Both tables read as cleared right after reset through
// per-entry valid flops, so no clearing pass is needed. slot_index reports the
// low four bits of the slot number.
module can_acceptance_filter_table
	import caft_pkg::*;
#(
	parameter int STD_SLOTS = DEF_STD_SLOTS,
	parameter int EXT_SLOTS = DEF_EXT_SLOTS
) (
	input  logic                  clk,
	input  logic                  arst_n,
	// request channel
	input  logic                  item_valid,
	output logic                  item_stall,
	input  logic                  op,
	input  logic                  is_extended,
	input  logic [EXT_ID_W-1:0]   frame_id,
	input  logic [EXT_ID_W-1:0]   id_mask,
	input  logic [MBOX_W-1:0]     fifo_sel,
	// result channel
	output logic                  result_valid,
	input  logic                  result_stall,
	output logic [1:0]            status,
	output logic [SLOT_OUT_W-1:0] slot_index,
	output logic                  was_update,
	output logic                  reject_std_unmatched,
	output logic                  reject_ext_unmatched
);

`include "can_acceptance_filter_table_assert.svh"

	caft_cmd_t  cmd;
	caft_stat_t stat;

	// sequencer: idle -> scan -> commit
	caft_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_stall (item_stall),
		.stat       (stat),
		.cmd        (cmd)
	);

	// tables, compare logic, flags and result register
	caft_datapath #(
		.STD_SLOTS (STD_SLOTS),
		.EXT_SLOTS (EXT_SLOTS)
	) u_datapath (
		.clk                  (clk),
		.arst_n               (arst_n),
		.cmd                  (cmd),
		.stat                 (stat),
		.op                   (op),
		.is_extended          (is_extended),
		.frame_id             (frame_id),
		.id_mask              (id_mask),
		.fifo_sel             (fifo_sel),
		.result_valid         (result_valid),
		.result_stall         (result_stall),
		.status               (status),
		.slot_index           (slot_index),
		.was_update           (was_update),
		.reject_std_unmatched (reject_std_unmatched),
		.reject_ext_unmatched (reject_ext_unmatched)
	);

	// a taken request keeps the input side closed for at least the scan
	`CAFT_ASSERT_NEXT(a_busy_after_take, item_valid && !item_stall, item_stall)
	// reject flags never clear once set
	`CAFT_ASSERT_NEXT(a_std_flag_sticky, reject_std_unmatched, reject_std_unmatched)
	`CAFT_ASSERT_NEXT(a_ext_flag_sticky, reject_ext_unmatched, reject_ext_unmatched)
	// an error result carries slot 0 and no update mark
	`CAFT_ASSERT_SAME(a_err_fields, result_valid && (status != ST_OK), (slot_index == '0) && !was_update)

endmodule

// ----- verif/tb.sv -----
// Self-checking testbench for the CAN acceptance filter table block.
module tb;
	import caft_pkg::*;

	// One filter request as presented on the request channel.
	typedef struct {
		logic                op;
		logic                ext;
		logic [EXT_ID_W-1:0] id;
		logic [EXT_ID_W-1:0] msk;
		logic [MBOX_W-1:0]   mbox;
		bit                  drain; // hold this request until all results are back
	} filt_req_t;

	// One result transfer.
	typedef struct {
		status_t               st;
		logic [SLOT_OUT_W-1:0] slot;
		logic                  upd;
		logic                  rej_std;
		logic                  rej_ext;
	} filt_resp_t;

	localparam int MAX_SLOTS = (DEF_STD_SLOTS > DEF_EXT_SLOTS) ? DEF_STD_SLOTS : DEF_EXT_SLOTS;
	localparam logic [EXT_ID_W-1:0] STD_BITS = 29'h7FF;
	localparam logic [EXT_ID_W-1:0] EXT_BITS = 29'h1FFFFFFF;

	logic                  clk;
	logic                  arst_n;
	logic                  item_valid;
	logic                  item_stall;
	logic                  op;
	logic                  is_extended;
	logic [EXT_ID_W-1:0]   frame_id;
	logic [EXT_ID_W-1:0]   id_mask;
	logic [MBOX_W-1:0]     fifo_sel;
	logic                  result_valid;
	logic                  result_stall;
	logic [1:0]            status;
	logic [SLOT_OUT_W-1:0] slot_index;
	logic                  was_update;
	logic                  reject_std_unmatched;
	logic                  reject_ext_unmatched;

	can_acceptance_filter_table dut (
		.clk                  (clk),
		.arst_n               (arst_n),
		.item_valid           (item_valid),
		.item_stall           (item_stall),
		.op                   (op),
		.is_extended          (is_extended),
		.frame_id             (frame_id),
		.id_mask              (id_mask),
		.fifo_sel             (fifo_sel),
		.result_valid         (result_valid),
		.result_stall         (result_stall),
		.status               (status),
		.slot_index           (slot_index),
		.was_update           (was_update),
		.reject_std_unmatched (reject_std_unmatched),
		.reject_ext_unmatched (reject_ext_unmatched)
	);

	// Shadow copy of both tables, indexed [0] standard, [1] extended.
	logic [EN_W-1:0]     shadow_en   [2][MAX_SLOTS];
	logic [EXT_ID_W-1:0] shadow_id   [2][MAX_SLOTS];
	logic [EXT_ID_W-1:0] shadow_mask [2][MAX_SLOTS];
	logic                shadow_reject [2];

	filt_req_t  filter_requests[$];    // requests not yet presented
	filt_resp_t filter_results_due[$]; // predicted results, oldest first

	int mismatch_count = 0;
	int send_gap = 0;
	int stall_left = 0;
	bit req_taken = 1'b0; // set at the rising edge that moved a request
	bit quiet = 1'b0;     // stretch with no idling on either side

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Generous cap, far beyond the slowest legal run.
	initial begin
		#2000000;
		$display("Mismatches found");
		$finish;
	end

	// Mostly short gaps, now and then a long one; none in a quiet stretch.
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (quiet || r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		if (r < 96)
			return $urandom_range(4, 8);
		return $urandom_range(15, 40);
	endfunction

	// Applies one request to the shadow tables and returns the expected result.
	// Lookup compares the stored identifier with the width-masked request
	// identifier over every slot, disabled ones included, so a stale or
	// reset-zero identifier still selects its slot.
	function automatic filt_resp_t predict_filter(filt_req_t r);
		filt_resp_t res;
		logic [EXT_ID_W-1:0] ident;
		logic [EXT_ID_W-1:0] msk;
		int c;
		int slots;
		int hit;
		int at;
		c     = r.ext ? 1 : 0;
		slots = r.ext ? DEF_EXT_SLOTS : DEF_STD_SLOTS;
		ident = r.id & (r.ext ? EXT_BITS : STD_BITS);
		msk   = r.msk & (r.ext ? EXT_BITS : STD_BITS);
		hit   = -1;
		for (int i = 0; i < slots; i++)
			if (hit < 0 && shadow_id[c][i] == ident)
				hit = i;
		res.st   = ST_OK;
		res.slot = '0;
		res.upd  = 1'b0;
		if (r.op == OP_REMOVE) begin
			// mailbox is don't-care on remove
			if (hit < 0) begin
				res.st = ST_NOT_FOUND;
			end else begin
				shadow_en[c][hit] = EN_DISABLED;
				res.slot = hit[SLOT_OUT_W-1:0];
			end
		end else if (r.mbox > 8'd1) begin
			res.st = ST_BAD_MAILBOX;
		end else begin
			at = hit;
			if (at >= 0) begin
				res.upd = 1'b1;
			end else begin
				for (int i = 0; i < slots; i++)
					if (at < 0 && shadow_en[c][i] == EN_DISABLED)
						at = i;
			end
			if (at < 0) begin
				res.st = ST_FULL;
			end else begin
				shadow_en[c][at]   = r.mbox[EN_W-1:0] + 2'd1;
				shadow_id[c][at]   = ident;
				shadow_mask[c][at] = msk;
				shadow_reject[c]   = 1'b1;
				res.slot = at[SLOT_OUT_W-1:0];
			end
		end
		res.rej_std = shadow_reject[0];
		res.rej_ext = shadow_reject[1];
		return res;
	endfunction

	task automatic queue_request(input logic o, input logic x, input logic [EXT_ID_W-1:0] id,
			input logic [EXT_ID_W-1:0] msk, input logic [MBOX_W-1:0] mbox, input bit drain);
		filt_req_t r;
		r.op    = o;
		r.ext   = x;
		r.id    = id;
		r.msk   = msk;
		r.mbox  = mbox;
		r.drain = drain;
		filter_requests.push_back(r);
	endtask

	// Request driver: payload and valid change at the falling edge only.
	always @(negedge clk) begin : drive_requests
		filt_req_t nxt;
		logic      valid_next;
		if (arst_n) begin
			valid_next = item_valid;
			if (req_taken) begin
				req_taken  = 1'b0;
				valid_next = 1'b0;
				send_gap   = pick_gap();
				if ($urandom_range(0, 49) == 0)
					quiet = ~quiet;
			end
			if (!valid_next) begin
				if (send_gap > 0) begin
					send_gap--;
				end else if (filter_requests.size() > 0 &&
						!(filter_requests[0].drain && filter_results_due.size() > 0)) begin
					nxt = filter_requests.pop_front();
					op             <= nxt.op;
					is_extended    <= nxt.ext;
					frame_id       <= nxt.id;
					id_mask        <= nxt.msk;
					fifo_sel       <= nxt.mbox;
					valid_next = 1'b1;
				end
			end
			// single update per step keeps valid high across back-to-back transfers
			item_valid <= valid_next;
		end
	end

	// Result side back-pressure, also changed at the falling edge.
	always @(negedge clk) begin
		if (arst_n) begin
			if (stall_left > 0) begin
				stall_left--;
				result_stall <= 1'b1;
			end else if (quiet || $urandom_range(0, 99) < 70) begin
				result_stall <= 1'b0;
			end else begin
				stall_left = pick_gap();
				result_stall <= 1'b1;
			end
		end
	end

	// Monitor: check any result transfer first, then predict the accepted request.
	always @(posedge clk) begin : watch_transfers
		filt_req_t  got_req;
		filt_resp_t want;
		if (arst_n) begin
			if (result_valid && !result_stall) begin
				if (filter_results_due.size() == 0) begin
					$error("result transfer with no request outstanding");
					mismatch_count++;
				end else begin
					want = filter_results_due.pop_front();
					if (status !== want.st) begin
						$error("status: expected %0d, got %0d", want.st, status);
						mismatch_count++;
					end
					if (slot_index !== want.slot) begin
						$error("slot_index: expected %0d, got %0d", want.slot, slot_index);
						mismatch_count++;
					end
					if (was_update !== want.upd) begin
						$error("was_update: expected %0d, got %0d", want.upd, was_update);
						mismatch_count++;
					end
					if (reject_std_unmatched !== want.rej_std) begin
						$error("reject_std_unmatched: expected %0d, got %0d",
							want.rej_std, reject_std_unmatched);
						mismatch_count++;
					end
					if (reject_ext_unmatched !== want.rej_ext) begin
						$error("reject_ext_unmatched: expected %0d, got %0d",
							want.rej_ext, reject_ext_unmatched);
						mismatch_count++;
					end
				end
			end
			if (item_valid && !item_stall) begin
				got_req.op    = op;
				got_req.ext   = is_extended;
				got_req.id    = frame_id;
				got_req.msk   = id_mask;
				got_req.mbox  = fifo_sel;
				got_req.drain = 1'b0;
				filter_results_due.push_back(predict_filter(got_req));
				req_taken = 1'b1;
			end
		end
	end

	// Stimulus, reset and end of run.
	initial begin : stimulus
		logic [EXT_ID_W-1:0] std_pool [22];
		logic [EXT_ID_W-1:0] ext_pool [12];
		logic [EXT_ID_W-1:0] id;
		logic [MBOX_W-1:0]   mbox;
		logic                x;
		logic                o;
		int                  remove_pct;

		arst_n         = 1'b0;
		item_valid     = 1'b0;
		op             = OP_ADD;
		is_extended    = 1'b0;
		frame_id       = '0;
		id_mask        = '0;
		fifo_sel       = '0;
		result_stall   = 1'b0;
		for (int c = 0; c < 2; c++) begin
			shadow_reject[c] = 1'b0;
			for (int i = 0; i < MAX_SLOTS; i++) begin
				shadow_en[c][i]   = EN_DISABLED;
				shadow_id[c][i]   = '0;
				shadow_mask[c][i] = '0;
			end
		end

		// Directed: reset-zero identifiers match disabled slots, not-found,
		// extremes, bad mailboxes, upper id bits ignored for standard,
		// extended table filled to the brim, then freed and reused.
		queue_request(OP_REMOVE, 1'b0, 29'd0, 29'd0, 8'd0, 1'b0);
		queue_request(OP_REMOVE, 1'b0, 29'd5, 29'd0, 8'd0, 1'b0);
		queue_request(OP_ADD, 1'b0, STD_BITS, STD_BITS, 8'd0, 1'b0);
		queue_request(OP_ADD, 1'b0, STD_BITS, 29'd0, 8'd1, 1'b0);
		queue_request(OP_ADD, 1'b0, 29'd3, 29'd3, 8'd2, 1'b0);
		queue_request(OP_ADD, 1'b1, 29'd3, 29'd3, 8'd255, 1'b0);
		queue_request(OP_ADD, 1'b0, EXT_BITS, EXT_BITS, 8'd1, 1'b0);
		queue_request(OP_ADD, 1'b1, EXT_BITS, EXT_BITS, 8'd0, 1'b0);
		queue_request(OP_ADD, 1'b1, 29'h10000000, 29'h0AAAAAAA, 8'd1, 1'b0);
		for (int i = 1; i <= 6; i++)
			queue_request(OP_ADD, 1'b1, EXT_ID_W'(i), 29'h15555555, MBOX_W'(i % 2), 1'b0);
		queue_request(OP_ADD, 1'b1, 29'd7, 29'd0, 8'd0, 1'b0);             // table full
		queue_request(OP_REMOVE, 1'b1, 29'h10000000, 29'd0, 8'd200, 1'b0); // mailbox ignored
		queue_request(OP_REMOVE, 1'b1, 29'h12345678, 29'd0, 8'd0, 1'b0);   // not found
		queue_request(OP_ADD, 1'b1, 29'd7, EXT_BITS, 8'd1, 1'b0);
		queue_request(OP_REMOVE, 1'b0, STD_BITS, 29'd0, 8'd9, 1'b0);
		queue_request(OP_ADD, 1'b0, 29'd0, 29'd0, 8'd0, 1'b0);

		// Small identifier pools keep hits, stale matches and full tables
		// common; slot 0 of each pool is zero to match untouched slots.
		std_pool[0] = '0;
		ext_pool[0] = '0;
		for (int i = 1; i < 22; i++)
			std_pool[i] = EXT_ID_W'($urandom()) & STD_BITS;
		for (int i = 1; i < 12; i++)
			ext_pool[i] = EXT_ID_W'($urandom()) & EXT_BITS;

		remove_pct = 30;
		for (int n = 0; n < 930; n++) begin
			// remove rate varies by block so the tables both fill and drain
			if (n % 64 == 0)
				case ($urandom_range(0, 2))
					0: remove_pct = 10;
					1: remove_pct = 30;
					default: remove_pct = 50;
				endcase
			o = ($urandom_range(0, 99) < remove_pct) ? OP_REMOVE : OP_ADD;
			x = ($urandom_range(0, 9) < 4);
			if ($urandom_range(0, 9) == 0)
				id = EXT_ID_W'($urandom()) & EXT_BITS;
			else if (x)
				id = ext_pool[$urandom_range(0, 11)];
			else
				id = (EXT_ID_W'($urandom()) & ~STD_BITS) | std_pool[$urandom_range(0, 21)];
			mbox = MBOX_W'(($urandom_range(0, 99) < 85) ? $urandom_range(0, 1) :
				$urandom_range(0, 255));
			queue_request(o, x, id, EXT_ID_W'($urandom()), mbox,
				n == 0 || $urandom_range(0, 99) == 0);
		end

		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (filter_requests.size() != 0 || item_valid || filter_results_due.size() != 0)
			@(posedge clk);
		repeat (40) @(posedge clk);
		if (mismatch_count == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule

// ----- files.f -----
+incdir+rtl/core
rtl/core/caft_pkg.sv
rtl/core/caft_ctrl.sv
rtl/core/caft_datapath.sv
rtl/core/can_acceptance_filter_table.sv
verif/tb.sv
